// File: rtl/ptbl_pkg.sv
package ptbl_pkg;

    localparam int TABLE_ENTRIES_DEF = 2048;

    localparam int          KEY_W     = 32;
    localparam int          TIME_W    = 64;
    localparam int          MT_W      = 42;
    localparam int          CNT_W     = 48;
    localparam int          CFG_IDX_W = 8;
    localparam int          CFG_W     = 32;
    localparam int          ADD_W     = 41;   // earned tokens, saturated at 2^40
    localparam int          SUM_W     = 51;   // bucket plus earned milli-tokens
    localparam int          DVD_W     = 96;   // elapsed * rate

    localparam logic [9:0]           MILLI      = 10'd1000;

    // M = ceil(2^82 / 5^9), split in two words.
    // For x < 2^70: floor(x / 1e9) = ((x >> 9) * M) >> 82
    localparam logic [31:0]          RCP_M_LO   = 32'd1303193958;
    localparam logic [29:0]          RCP_M_HI   = 30'd576460752;

    localparam logic [CFG_IDX_W-1:0] REG_REFILL_RATE = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BURST_LIMIT = 8'd1;

    typedef struct packed {
        logic valid;
        logic [KEY_W-1:0]  key;
        logic [MT_W-1:0]   mt;
        logic [TIME_W-1:0] last;
    } slot_t;

    typedef struct packed {
        logic clear_wr;
        logic accept;
        logic read_eval;
        logic mul_lo;
        logic mul_hi;
        logic div_load;
        logic rcp_lo;
        logic rcp_hi;
        logic rcp_sum;
        logic scale;
        logic update;
        logic commit;
    } cmd_t;

    typedef struct packed {
        logic clear_last;
        logic hit;
    } stat_t;

endpackage

// File: rtl/per_source_token_bucket_limiter_unit.sv
// channel | signals                                           | moves
// input   | in_valid, in_ready, source_address, arrival_time  | one packet per beat
// output  | out_valid, out_ready, pass, entry_replaced,       | one result per beat
//         | passed_count, dropped_count                       |
// config  | cfg_valid, cfg_ready, cfg_index, cfg_data         | one register write per beat
//
// Miss or new source: the beat goes through read, update and write; the next beat can be
// taken in the cycle the result turns valid. Hit: the path adds the elapsed*rate multiply
// (2 steps), a sum, the reciprocal multiply for the divide by 1e9 (3 steps) and a scale.
// After reset, a clearing pass writes one table entry after another with in_ready low;
// config writes are taken throughout.
// A finished result sits in the output register; the next packet is accepted
// meanwhile and waits only at its own commit if the output is still stalled.
module per_source_token_bucket_limiter_unit
    import ptbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  logic [KEY_W-1:0]     source_address,
    input  logic [TIME_W-1:0]    arrival_time,
    output logic                 out_valid,
    input  logic                 out_ready,
    output logic                 pass,
    output logic                 entry_replaced,
    output logic [CNT_W-1:0]     passed_count,
    output logic [CNT_W-1:0]     dropped_count,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_data
);

    cmd_t  cmd;
    stat_t stat;

    assign cfg_ready = 1'b1;

    ptbl_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    ptbl_dp #(
        .TABLE_ENTRIES (TABLE_ENTRIES)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .source_address (source_address),
        .arrival_time   (arrival_time),
        .cfg_valid      (cfg_valid),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .pass           (pass),
        .entry_replaced (entry_replaced),
        .passed_count   (passed_count),
        .dropped_count  (dropped_count)
    );

endmodule

// File: rtl/ptbl_ctrl.sv
module ptbl_ctrl
    import ptbl_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    input  logic  in_valid,
    output logic  in_ready,
    output logic  out_valid,
    input  logic  out_ready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [11:0] {
        ST_CLEAR   = 12'b000000000001,
        ST_IDLE    = 12'b000000000010,
        ST_READ    = 12'b000000000100,
        ST_MUL_LO  = 12'b000000001000,
        ST_MUL_HI  = 12'b000000010000,
        ST_SUM     = 12'b000000100000,
        ST_RCP_LO  = 12'b000001000000,
        ST_RCP_HI  = 12'b000010000000,
        ST_RCP_SUM = 12'b000100000000,
        ST_SCALE   = 12'b001000000000,
        ST_UPDATE  = 12'b010000000000,
        ST_WRITE   = 12'b100000000000
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;
    logic   out_free;

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    always_comb
    begin
        state_next     = state_reg;
        out_valid_next = out_valid_reg && !out_ready;
        cmd            = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                cmd.clear_wr = 1'b1;
                if (stat.clear_last)
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.accept = 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                cmd.read_eval = 1'b1;
                state_next    = stat.hit ? ST_MUL_LO : ST_UPDATE;
            end
            ST_MUL_LO:
            begin
                cmd.mul_lo = 1'b1;
                state_next = ST_MUL_HI;
            end
            ST_MUL_HI:
            begin
                cmd.mul_hi = 1'b1;
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                cmd.div_load = 1'b1;
                state_next   = ST_RCP_LO;
            end
            ST_RCP_LO:
            begin
                cmd.rcp_lo = 1'b1;
                state_next = ST_RCP_HI;
            end
            ST_RCP_HI:
            begin
                cmd.rcp_hi = 1'b1;
                state_next = ST_RCP_SUM;
            end
            ST_RCP_SUM:
            begin
                cmd.rcp_sum = 1'b1;
                state_next  = ST_SCALE;
            end
            ST_SCALE:
            begin
                cmd.scale  = 1'b1;
                state_next = ST_UPDATE;
            end
            ST_UPDATE:
            begin
                cmd.update = 1'b1;
                state_next = ST_WRITE;
            end
            ST_WRITE:
            begin
                // hold here until the output stage can take the beat
                if (out_free)
                begin
                    cmd.commit     = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_accept_reads: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> state_reg == ST_READ)
        else $error("accepted beat did not start a table read");

    a_out_from_write: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(state_reg == ST_WRITE))
        else $error("result appeared without a commit");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> out_free)
        else $error("commit would overwrite an untaken result");

    a_clear_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.clear_wr |-> !in_ready)
        else $error("input taken during table clear");

endmodule

// File: rtl/ptbl_dp.sv
module ptbl_dp
    import ptbl_pkg::*;
#(
    parameter int TABLE_ENTRIES = TABLE_ENTRIES_DEF
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    output stat_t              stat,
    input  logic [KEY_W-1:0]   source_address,
    input  logic [TIME_W-1:0]  arrival_time,
    input  logic               cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    output logic               pass,
    output logic               entry_replaced,
    output logic [CNT_W-1:0]   passed_count,
    output logic [CNT_W-1:0]   dropped_count
);

    localparam int IDX_W = $clog2(TABLE_ENTRIES);

    slot_t mem [TABLE_ENTRIES];

    logic [CFG_W-1:0]     rate_reg, burst_reg;
    logic [IDX_W-1:0]     clear_idx_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [KEY_W-1:0]     key_reg;
    logic [TIME_W-1:0]    time_reg;
    slot_t                rd_reg;
    logic                 hit_reg;
    logic [TIME_W-1:0]    elapsed_reg;
    logic [MT_W-1:0]      cap_reg;
    logic [63:0]          p0_reg, p1_reg;
    logic [DVD_W-1:0]     dvd_reg;
    logic [63:0]          pp00_reg, pp10_reg, pp01_reg, pp11_reg;
    logic [ADD_W-1:0]     quot_reg;
    logic                 sat_reg;
    logic [SUM_W-1:0]     add_mt_reg;
    logic [MT_W-1:0]      tok_reg;
    logic                 pass_reg, repl_reg;
    logic [CNT_W-1:0]     passed_reg, dropped_reg;

    logic [KEY_W-1:0]     h0, h1;
    logic [IDX_W-1:0]     idx_in;
    logic                 hit_now;
    logic [31:0]          x_lo;
    logic [28:0]          x_hi;
    logic [127:0]         rcp_full;
    logic [ADD_W-1:0]     add_tok;
    logic [SUM_W-1:0]     sum;
    logic [MT_W-1:0]      tok_next;
    logic [MT_W-1:0]      tok_wr;
    slot_t                wr_slot;

    assign h0     = source_address ^ (source_address >> 16);
    assign h1     = h0 ^ (h0 >> 4);
    assign idx_in = h1[IDX_W-1:0];

    assign hit_now = rd_reg.valid && (rd_reg.key == key_reg);

    // 1e9 = 2^9 * 5^9: drop nine bits, then multiply by the reciprocal of 5^9
    assign x_lo     = dvd_reg[40:9];
    assign x_hi     = dvd_reg[69:41];
    assign rcp_full = {pp11_reg, 64'd0} + {32'd0, pp10_reg, 32'd0}
                    + {32'd0, pp01_reg, 32'd0} + {64'd0, pp00_reg};

    assign add_tok = (sat_reg || quot_reg[ADD_W-1]) ? {1'b1, {(ADD_W-1){1'b0}}} : quot_reg;

    assign sum      = SUM_W'(rd_reg.mt) + add_mt_reg;
    assign tok_next = !hit_reg ? cap_reg
                    : (sum > SUM_W'(cap_reg)) ? cap_reg : sum[MT_W-1:0];
    assign tok_wr   = pass_reg ? (tok_reg - MT_W'(MILLI)) : tok_reg;

    assign stat.clear_last = &clear_idx_reg;
    assign stat.hit        = hit_now;

    always_comb
    begin
        wr_slot = '0;
        if (cmd.commit)
        begin
            wr_slot.valid = 1'b1;
            wr_slot.key   = key_reg;
            wr_slot.mt    = tok_wr;
            wr_slot.last  = time_reg;
        end
    end

    // table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (cmd.clear_wr)
        begin
            mem[clear_idx_reg] <= wr_slot;
        end
        else if (cmd.commit)
        begin
            mem[idx_reg] <= wr_slot;
        end
        if (cmd.accept)
        begin
            rd_reg <= mem[idx_in];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg      <= '0;
            burst_reg     <= '0;
            clear_idx_reg <= '0;
            passed_reg    <= '0;
            dropped_reg   <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_index == REG_REFILL_RATE)
            begin
                rate_reg <= cfg_data;
            end
            if (cfg_valid && cfg_index == REG_BURST_LIMIT)
            begin
                burst_reg <= cfg_data;
            end
            if (cmd.clear_wr)
            begin
                clear_idx_reg <= clear_idx_reg + IDX_W'(1);
            end
            if (cmd.commit)
            begin
                if (pass_reg)
                begin
                    passed_reg <= passed_reg + CNT_W'(1);
                end
                else
                begin
                    dropped_reg <= dropped_reg + CNT_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            idx_reg  <= idx_in;
            key_reg  <= source_address;
            time_reg <= arrival_time;
        end
        if (cmd.read_eval)
        begin
            hit_reg     <= hit_now;
            elapsed_reg <= time_reg - rd_reg.last;
            cap_reg     <= MT_W'(burst_reg) * MT_W'(MILLI);
        end
        if (cmd.mul_lo)
        begin
            p0_reg <= elapsed_reg[31:0] * rate_reg;
        end
        if (cmd.mul_hi)
        begin
            p1_reg <= elapsed_reg[63:32] * rate_reg;
        end
        if (cmd.div_load)
        begin
            dvd_reg <= {32'd0, p0_reg} + {p1_reg, 32'd0};
        end
        // floor(elapsed * rate / 1e9); anything from 2^70 up saturates anyway
        if (cmd.rcp_lo)
        begin
            pp00_reg <= x_lo * RCP_M_LO;
            pp10_reg <= x_hi * RCP_M_LO;
            sat_reg  <= |dvd_reg[DVD_W-1:70];
        end
        if (cmd.rcp_hi)
        begin
            pp01_reg <= x_lo * RCP_M_HI;
            pp11_reg <= x_hi * RCP_M_HI;
        end
        if (cmd.rcp_sum)
        begin
            quot_reg <= rcp_full[122:82];
        end
        if (cmd.scale)
        begin
            add_mt_reg <= add_tok * MILLI;
        end
        if (cmd.update)
        begin
            tok_reg  <= tok_next;
            pass_reg <= (tok_next >= MT_W'(MILLI));
            repl_reg <= !hit_reg;
        end
        if (cmd.commit)
        begin
            pass           <= pass_reg;
            entry_replaced <= repl_reg;
            passed_count   <= pass_reg ? passed_reg + CNT_W'(1) : passed_reg;
            dropped_count  <= pass_reg ? dropped_reg : dropped_reg + CNT_W'(1);
        end
    end

    a_add_capped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.scale |-> add_tok <= {1'b1, {(ADD_W-1){1'b0}}})
        else $error("earned tokens above saturation");

    a_tok_capped: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.update |-> tok_next <= cap_reg)
        else $error("bucket above burst");

    a_one_count: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> ($countones({passed_reg != $past(passed_reg),
                                    dropped_reg != $past(dropped_reg)}) == 1))
        else $error("commit must bump exactly one counter");

endmodule

// File: test/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import ptbl_pkg::*;

    localparam int                   SLOTS        = TABLE_ENTRIES_DEF;
    localparam longint unsigned      TOKEN_MILLI  = 64'd1000;
    localparam longint unsigned      NS_SEC       = 64'd1000000000;
    localparam longint unsigned      EARN_CAP     = 64'd1 << 40;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED   = 8'd7;
    localparam logic [KEY_W-1:0]     ALIAS_FLIP   = 32'h8800_8800;
    localparam int                   DRAIN_CYCLES = 200;

    typedef struct {
        bit            pass;
        bit            replaced;
        bit [CNT_W-1:0] passed;
        bit [CNT_W-1:0] dropped;
    } verdict_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_ready;
    logic [KEY_W-1:0]     source_address;
    logic [TIME_W-1:0]    arrival_time;
    logic                 out_valid;
    logic                 out_ready;
    logic                 pass;
    logic                 entry_replaced;
    logic [CNT_W-1:0]     passed_count;
    logic [CNT_W-1:0]     dropped_count;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_data;

    per_source_token_bucket_limiter_unit dut (.*);

    // bucket table mirror
    bit                  bk_valid [SLOTS];
    bit [KEY_W-1:0]      bk_key   [SLOTS];
    longint unsigned     bk_milli [SLOTS];
    longint unsigned     bk_last  [SLOTS];
    bit [CNT_W-1:0]      tot_passed;
    bit [CNT_W-1:0]      tot_dropped;
    longint unsigned     rate_reg;
    longint unsigned     burst_reg;

    verdict_t            pending_verdicts[$];
    int                  errors;
    bit                  send_idle_on;
    bit                  recv_idle_on;
    int                  hold_request;
    int                  hold_left;

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    function automatic int bucket_of(bit [KEY_W-1:0] a);
        bit [31:0] h;
        h = a ^ (a >> 16);
        h = h ^ (h >> 4);
        return int'(h[10:0]) & (SLOTS - 1);
    endfunction

    function automatic longint unsigned tokens_earned(longint unsigned elapsed,
                                                      longint unsigned rate);
        longint unsigned q;
        longint unsigned r;
        longint unsigned sum;
        q = elapsed / NS_SEC;
        r = elapsed % NS_SEC;
        if (rate != 0 && q > EARN_CAP / rate)
            return EARN_CAP;
        sum = q * rate + (r * rate) / NS_SEC;
        return (sum > EARN_CAP) ? EARN_CAP : sum;
    endfunction

    function automatic verdict_t police_packet(bit [KEY_W-1:0] a, bit [TIME_W-1:0] t);
        verdict_t v;
        int s;
        longint unsigned cap;
        longint unsigned tok;
        s = bucket_of(a);
        cap = burst_reg * TOKEN_MILLI;
        v.replaced = !bk_valid[s] || bk_key[s] != a;
        if (v.replaced)
        begin
            bk_valid[s] = 1'b1;
            bk_key[s] = a;
            tok = cap;
        end
        else
        begin
            tok = bk_milli[s] + tokens_earned(t - bk_last[s], rate_reg) * TOKEN_MILLI;
            if (tok > cap)
                tok = cap;
        end
        bk_last[s] = t;
        v.pass = tok >= TOKEN_MILLI;
        if (v.pass)
        begin
            tok -= TOKEN_MILLI;
            tot_passed++;
        end
        else
            tot_dropped++;
        bk_milli[s] = tok & ((64'd1 << MT_W) - 1);
        v.passed = tot_passed;
        v.dropped = tot_dropped;
        return v;
    endfunction

    task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
        $display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
        errors++;
    endtask

    // result checker
    always @(posedge clk)
    begin
        verdict_t v;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_verdicts.size() == 0)
                report_mismatch("unexpected result beat", 1, 0);
            else
            begin
                v = pending_verdicts.pop_front();
                if (pass !== v.pass)
                    report_mismatch("pass", pass, v.pass);
                if (entry_replaced !== v.replaced)
                    report_mismatch("entry_replaced", entry_replaced, v.replaced);
                if (passed_count !== v.passed)
                    report_mismatch("passed_count", passed_count, v.passed);
                if (dropped_count !== v.dropped)
                    report_mismatch("dropped_count", dropped_count, v.dropped);
            end
        end
    end

    // receiver: random idling plus long hold-off on request
    always @(negedge clk)
    begin
        if (hold_request > 0)
        begin
            hold_left = hold_request;
            hold_request = 0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
            out_ready <= !(recv_idle_on && $urandom_range(99) < 10);
    end

    task automatic send_packet(bit [KEY_W-1:0] a, bit [TIME_W-1:0] t);
        @(negedge clk);
        while (send_idle_on && $urandom_range(99) < 10)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        source_address <= a;
        arrival_time <= t;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        pending_verdicts.push_back(police_packet(a, t));
    endtask

    task automatic wait_drained();
        @(negedge clk);
        in_valid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] data);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        if (idx == REG_REFILL_RATE)
            rate_reg = data;
        else if (idx == REG_BURST_LIMIT)
            burst_reg = data;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic set_policy(logic [CFG_W-1:0] rate, logic [CFG_W-1:0] burst);
        wait_drained();
        write_reg(REG_REFILL_RATE, rate);
        write_reg(REG_BURST_LIMIT, burst);
    endtask

    task automatic test_zero_burst();
        send_packet(32'h0000_0000, 64'd0);
        send_packet(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_packet(32'h0000_0000, 64'd5);
    endtask

    task automatic test_extremes();
        set_policy(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        write_reg(REG_UNUSED, 32'h0000_0001);   // must be ignored
        send_packet(32'h0000_0000, 64'd0);
        send_packet(32'h0000_0000, 64'd0);
        send_packet(32'h0000_0000, 64'hFFFF_FFFF_FFFF_FFFF);
        send_packet(32'h0000_0000, 64'd3);      // time goes backwards
        send_packet(32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF);
        send_packet(32'hFFFF_FFFF, 64'h0000_0000_0000_0000);
        send_packet(32'hA5A5_5A5A, 64'h5A5A_A5A5_5A5A_A5A5);
        send_packet(32'hA5A5_5A5A, 64'hA5A5_5A5A_A5A5_5A5A);
    endtask

    task automatic test_aliasing();
        bit [KEY_W-1:0] a;
        set_policy(32'd1, 32'd2);
        a = $urandom;
        send_packet(a, 64'd100);
        send_packet(a ^ ALIAS_FLIP, 64'd200);   // same slot, other source
        send_packet(a, 64'd300);
        send_packet(a, 64'd400);
        send_packet(a, 64'd500);
        send_packet(a, 64'd500 + NS_SEC);       // one token earned
    endtask

    task automatic test_burst_lowered();
        set_policy(32'd0, 32'd10);
        send_packet(32'h0A00_0001, 64'd10);
        send_packet(32'h0A00_0001, 64'd20);
        set_policy(32'd0, 32'd2);
        send_packet(32'h0A00_0001, 64'd30);
        send_packet(32'h0A00_0001, 64'd40);
        send_packet(32'h0A00_0001, 64'd50);
    endtask

    task automatic test_backpressure();
        bit [KEY_W-1:0] a;
        int i;
        set_policy(32'd5, 32'd3);
        a = $urandom;
        hold_request = 400;
        for (i = 0; i < 20; i++)
            send_packet((i % 3 == 0) ? a : $urandom, 64'd1000 * i);
    endtask

    task automatic run_random_phase(int count, logic [CFG_W-1:0] rate,
                                    logic [CFG_W-1:0] burst, bit quiet);
        bit [KEY_W-1:0]  pool [16];
        longint unsigned clock_of [16];
        int i;
        int k;
        int pick;
        set_policy(rate, burst);
        send_idle_on = !quiet;
        recv_idle_on = !quiet;
        for (i = 0; i < 16; i++)
        begin
            pool[i] = (i % 4 == 3) ? (pool[i-1] ^ ALIAS_FLIP) : $urandom;
            clock_of[i] = {$urandom, $urandom} >> $urandom_range(63, 4);
        end
        for (i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 5)
                send_packet($urandom, {$urandom, $urandom});   // noise
            else
            begin
                k = $urandom_range(15);
                pick = $urandom_range(99);
                if (pick < 20)
                    clock_of[k] += $urandom_range(1000);
                else if (pick < 70)
                    clock_of[k] += $urandom_range(400_000_000);
                else if (pick < 92)
                    clock_of[k] += longint'($urandom_range(5)) * NS_SEC + $urandom;
                else if (pick < 96)
                    clock_of[k] -= $urandom_range(1_000_000);   // backwards
                else
                    clock_of[k] = {$urandom, $urandom};
                send_packet(pool[k], clock_of[k]);
            end
        end
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
    endtask

    task automatic test_random();
        run_random_phase(300, 32'd3, 32'd4, 1'b0);
        run_random_phase(250, 32'd1, 32'd1, 1'b1);
        run_random_phase(250, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b0);
        run_random_phase(250, 32'd0, 32'd0, 1'b0);
        run_random_phase(300, $urandom_range(20), $urandom_range(8), 1'b0);
    endtask

    initial
    begin
        int i;
        errors = 0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        source_address = '0;
        arrival_time = '0;
        out_ready = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        hold_request = 0;
        hold_left = 0;
        rate_reg = 0;
        burst_reg = 0;
        tot_passed = '0;
        tot_dropped = '0;
        for (i = 0; i < SLOTS; i++)
            bk_valid[i] = 1'b0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_zero_burst();
        test_extremes();
        test_aliasing();
        test_burst_lowered();
        test_backpressure();
        test_random();
        wait_drained();

        if (errors == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial
    begin
        #(40_000_000);
        $display("simulation failed");
        $finish;
    end

endmodule

// File: files.f
rtl/ptbl_pkg.sv
rtl/ptbl_ctrl.sv
rtl/ptbl_dp.sv
rtl/per_source_token_bucket_limiter_unit.sv
test/tb_top.sv
